/* rtl/ptmt_pkg.sv */
// Shared types and constants of the probe timestamp match table.
package ptmt_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 256;
   localparam int USEC_PER_SEC        = 1000000;

   localparam logic       ACTION_INSERT   = 1'b0;
   localparam logic       ACTION_MATCH    = 1'b1;
   localparam logic [1:0] STATUS_RECEIVED = 2'd1;

   typedef struct packed {
      logic        action;
      logic [15:0] seq_num;
      logic [15:0] port;
      logic [31:0] time_sec;
      logic [19:0] time_usec;
      logic [1:0]  entry_status;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [15:0]        matched_seq;
      logic [1:0]         prior_status;
      logic signed [31:0] delay_us;
   } rsp_type;

   typedef struct packed {
      logic [15:0] seq;
      logic [15:0] port;
      logic [31:0] sec;
      logic [19:0] usec;
      logic [1:0]  status;
   } entry_type;

endpackage

/* rtl/ptmt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ptmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/probe_timestamp_match_table.sv */
// Top level of the probe timestamp match table: ring table of sent probes with RTT lookup.
//
// The table of sent probes lives in one RAM of TABLE_DEPTH entries. After
// reset the block writes zeros through the whole table and holds req_stall
// high meanwhile. An insert transaction writes its entry at the write
// pointer, which then advances and wraps at TABLE_DEPTH. A match transaction
// scans the table from index 0 upwards, one entry per cycle through the single
// RAM read port, and stops at the first hit; a hit passes through the DIFF,
// MUL and SUM states to the OUT state, a miss goes straight to OUT. Only one
// transaction is in the block at a time; a finished response sits in the
// output register, so an insert may be taken while it waits to be collected.
module probe_timestamp_match_table #(
   parameter int TABLE_DEPTH = ptmt_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ptmt_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ptmt_pkg::rsp_type rsp_payload
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam logic [AW-1:0] LAST_INDEX = AW'(TABLE_DEPTH - 1);
   localparam logic signed [20:0] USEC_MUL = 21'(ptmt_pkg::USEC_PER_SEC);
   localparam logic signed [54:0] SAT_HI = 55'sd2147483647;
   localparam logic signed [54:0] SAT_LO = -55'sd2147483648;

   // sequencer states
   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_DIFF  = 3'd3;
   localparam logic [2:0] ST_MUL   = 3'd4;
   localparam logic [2:0] ST_SUM   = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;

   // control registers
   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] check_ff, check_in;   // clear address, then scan index
   logic [AW-1:0] wp_ff, wp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // payload registers
   ptmt_pkg::req_type   req_ff, req_in;
   ptmt_pkg::entry_type entry_ff, entry_in;
   logic [AW-1:0]       pos_ff, pos_in;
   logic signed [32:0]  sec_gap_ff, sec_gap_in;
   logic signed [21:0]  usec_adj_ff, usec_adj_in;
   logic signed [53:0]  prod_ff, prod_in;
   ptmt_pkg::rsp_type   res_ff, res_in;
   ptmt_pkg::rsp_type   rsp_payload_ff, rsp_payload_in;

   // RAM port
   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr;
   ptmt_pkg::entry_type ram_wr_data;
   logic [AW-1:0]       ram_rd_addr;
   ptmt_pkg::entry_type ram_rd_data;

   logic               req_take;
   logic               out_free;
   logic               entry_hit;
   logic signed [20:0] usec_gap;
   logic signed [54:0] total;

   ptmt_ram #(
      .WIDTH ($bits(ptmt_pkg::entry_type)),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   // the output register may be loaded once the previous response is gone
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // sequence lookup, or port lookup when the sequence is zero
   assign entry_hit = (req_ff.seq_num != 16'd0) ? (ram_rd_data.seq == req_ff.seq_num)
                                                 : (ram_rd_data.port == req_ff.port);

   // read address: entry 0 while idle so the first word is ready on entry to scan
   always_comb begin
      if (state_ff == ST_SCAN && check_ff != LAST_INDEX) begin
         ram_rd_addr = check_ff + AW'(1);
      end else begin
         ram_rd_addr = '0;
      end
   end

   // delay arithmetic
   assign usec_gap = $signed({1'b0, req_ff.time_usec}) - $signed({1'b0, entry_ff.usec});
   assign total    = 55'(prod_ff) + 55'(usec_adj_ff);

   always_comb begin
      state_in       = state_ff;
      check_in       = check_ff;
      wp_in          = wp_ff;
      rsp_valid_in   = rsp_valid_ff;
      req_in         = req_ff;
      entry_in       = entry_ff;
      pos_in         = pos_ff;
      sec_gap_in     = sec_gap_ff;
      usec_adj_in    = usec_adj_ff;
      prod_in        = prod_ff;
      res_in         = res_ff;
      rsp_payload_in = rsp_payload_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = wp_ff;
      ram_wr_data    = '0;

      // drop the response once collected
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            // zero one entry per cycle
            ram_wr_en   = 1'b1;
            ram_wr_addr = check_ff;
            ram_wr_data = '0;
            if (check_ff == LAST_INDEX) begin
               state_in = ST_IDLE;
            end else begin
               check_in = check_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               req_in = req_payload;
               if (req_payload.action == ptmt_pkg::ACTION_INSERT) begin
                  // write at the pointer and advance with wrap
                  ram_wr_en          = 1'b1;
                  ram_wr_addr        = wp_ff;
                  ram_wr_data.seq    = req_payload.seq_num;
                  ram_wr_data.port   = req_payload.port;
                  ram_wr_data.sec    = req_payload.time_sec;
                  ram_wr_data.usec   = req_payload.time_usec;
                  ram_wr_data.status = req_payload.entry_status;
                  wp_in = (wp_ff == LAST_INDEX) ? '0 : wp_ff + AW'(1);
               end else begin
                  check_in = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // read data belongs to index check_ff
            if (entry_hit) begin
               entry_in = ram_rd_data;
               pos_in   = check_ff;
               state_in = ST_DIFF;
            end else if (check_ff == LAST_INDEX) begin
               res_in.found        = 1'b0;
               res_in.matched_seq  = req_ff.seq_num;
               res_in.prior_status = 2'd0;
               res_in.delay_us     = '0;
               state_in            = ST_OUT;
            end else begin
               check_in = check_ff + AW'(1);
            end
         end
         ST_DIFF: begin
            // write back the entry marked received
            ram_wr_en          = 1'b1;
            ram_wr_addr        = pos_ff;
            ram_wr_data        = entry_ff;
            ram_wr_data.status = ptmt_pkg::STATUS_RECEIVED;
            sec_gap_in = $signed({1'b0, req_ff.time_sec}) - $signed({1'b0, entry_ff.sec});
            // same second with a negative microsecond difference: add one second
            if (sec_gap_in == 33'sd0 && usec_gap < 21'sd0) begin
               usec_adj_in = 22'(usec_gap) + 22'(ptmt_pkg::USEC_PER_SEC);
            end else begin
               usec_adj_in = 22'(usec_gap);
            end
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = sec_gap_ff * USEC_MUL;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            res_in.found        = 1'b1;
            res_in.matched_seq  = entry_ff.seq;
            res_in.prior_status = entry_ff.status;
            // saturate to the signed 32-bit range
            if (total > SAT_HI) begin
               res_in.delay_us = 32'sh7fffffff;
            end else if (total < SAT_LO) begin
               res_in.delay_us = 32'sh80000000;
            end else begin
               res_in.delay_us = 32'(total);
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_payload_in = res_ff;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         check_ff     <= '0;
         wp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         check_ff     <= check_in;
         wp_ff        <= wp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff         <= req_in;
      entry_ff       <= entry_in;
      pos_ff         <= pos_in;
      sec_gap_ff     <= sec_gap_in;
      usec_adj_ff    <= usec_adj_in;
      prod_ff        <= prod_in;
      res_ff         <= res_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // a response only appears from the output state
   a_rsp_from_out : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("response raised outside the output state");

   // a finished result waits while the previous response is still stalled
   a_out_holds : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && rsp_valid_ff && rsp_stall) |=> state_ff == ST_OUT)
      else $error("result moved over a stalled response");

   // a miss carries zero status and zero delay
   a_miss_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_payload_ff.found) |->
         (rsp_payload_ff.delay_us == 32'sd0 && rsp_payload_ff.prior_status == 2'd0))
      else $error("miss response with nonzero fields");

endmodule

/* tb/ptmt_checker.sv */
// Checker for the probe timestamp match table: predicts each reply and compares it.
module ptmt_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  ptmt_pkg::req_type req_payload,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  ptmt_pkg::rsp_type rsp_payload,
   output int                fail_count,
   output int                outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     DEPTH     = ptmt_pkg::TABLE_DEPTH_DEFAULT;
   localparam longint DELAY_MAX = 64'sd2147483647;
   localparam longint DELAY_MIN = -64'sd2147483648;

   ptmt_pkg::entry_type probe_table [DEPTH];
   int unsigned         write_slot;
   ptmt_pkg::rsp_type   replies_due [$];

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   // Exact microsecond delay, saturated to the signed 32-bit range.
   function automatic logic signed [31:0] round_trip_us(logic [31:0] recv_sec,
                                                        logic [19:0] recv_usec,
                                                        ptmt_pkg::entry_type sent);
      longint secs_apart;
      longint usecs_apart;
      longint total;
      secs_apart  = longint'({32'd0, recv_sec}) - longint'({32'd0, sent.sec});
      usecs_apart = longint'({44'd0, recv_usec}) - longint'({44'd0, sent.usec});
      if (secs_apart == 0 && usecs_apart < 0) begin
         usecs_apart += ptmt_pkg::USEC_PER_SEC;
      end
      total = secs_apart * ptmt_pkg::USEC_PER_SEC + usecs_apart;
      if (total > DELAY_MAX) begin
         total = DELAY_MAX;
      end
      if (total < DELAY_MIN) begin
         total = DELAY_MIN;
      end
      return total[31:0];
   endfunction

   // Scan from index 0, take the first hit and mark it received.
   task automatic answer_reply(input ptmt_pkg::req_type reply,
                               output ptmt_pkg::rsp_type result);
      int   idx;
      logic hit;
      logic eq;
      hit                 = 1'b0;
      result.found        = 1'b0;
      result.matched_seq  = reply.seq_num;
      result.prior_status = '0;
      result.delay_us     = '0;
      for (idx = 0; idx < DEPTH && !hit; idx++) begin
         eq = (reply.seq_num != 0) ? (probe_table[idx].seq == reply.seq_num)
                                   : (probe_table[idx].port == reply.port);
         if (eq) begin
            hit                       = 1'b1;
            result.found              = 1'b1;
            result.matched_seq        = probe_table[idx].seq;
            result.prior_status       = probe_table[idx].status;
            result.delay_us           = round_trip_us(reply.time_sec, reply.time_usec,
                                                      probe_table[idx]);
            probe_table[idx].status   = ptmt_pkg::STATUS_RECEIVED;
         end
      end
   endtask

   task automatic compare_field(string field, longint want, longint got);
      if (want != got) begin
         fail_count++;
         $display("%0t: reply field %s wrong, expected %0d, actual %0d",
                  $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      ptmt_pkg::rsp_type want;
      ptmt_pkg::rsp_type seen;
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            probe_table[i] = '0;
         end
         write_slot = 0;
         replies_due.delete();
         outstanding = 0;
      end else begin
         if (req_valid && !req_stall) begin
            if (req_payload.action == ptmt_pkg::ACTION_INSERT) begin
               probe_table[write_slot].seq    = req_payload.seq_num;
               probe_table[write_slot].port   = req_payload.port;
               probe_table[write_slot].sec    = req_payload.time_sec;
               probe_table[write_slot].usec   = req_payload.time_usec;
               probe_table[write_slot].status = req_payload.entry_status;
               write_slot = (write_slot + 1) % DEPTH;
            end else begin
               answer_reply(req_payload, want);
               replies_due.push_back(want);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            seen = rsp_payload;
            if (replies_due.size() == 0) begin
               fail_count++;
               $display("%0t: reply with none expected, actual found %0d seq %0d delay %0d",
                        $time, seen.found, seen.matched_seq, seen.delay_us);
            end else begin
               want = replies_due.pop_front();
               compare_field("found", want.found, seen.found);
               compare_field("matched_seq", want.matched_seq, seen.matched_seq);
               compare_field("prior_status", want.prior_status, seen.prior_status);
               compare_field("delay_us", $signed(want.delay_us), $signed(seen.delay_us));
            end
         end
         outstanding = replies_due.size();
      end
   end

endmodule

/* tb/testbench.sv */
// Top of the probe timestamp match table testbench: stimulus, idling and verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // Random transactions per idling phase; three phases in all.
   localparam int     PHASE_ITEMS  = 128;
   // Longest single transaction is a hit at the last index; wait comfortably
   // past that once the replies have all arrived.
   localparam int     DRAIN_CYCLES = 300;
   localparam longint CYCLE_LIMIT  = 2_000_000;
   localparam int     HOLD_CYCLES  = 600;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   ptmt_pkg::req_type req_payload;
   logic              rsp_valid;
   logic              rsp_stall;
   ptmt_pkg::rsp_type rsp_payload;
   int                fail_count;
   int                outstanding;

   int      send_idle_pct   = 33;
   int      rsp_stall_pct   = 83;
   int      rsp_hold_cycles = 0;
   longint  cycle_count     = 0;

   // Recently accepted inserts, kept so that replies can aim at real entries.
   ptmt_pkg::req_type recent_probes [$];

   probe_timestamp_match_table u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   ptmt_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Abandon the run if it hangs: a lost reply or a stuck stall.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Receiver: stall at random, or hold off completely while a hold count
   // is loaded, so that the block fills up and pushes back on its input.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold_cycles--;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
         end
      end
   end

   function automatic ptmt_pkg::req_type probe(logic action, logic [15:0] seq,
                                               logic [15:0] port, logic [31:0] sec,
                                               logic [19:0] usec, logic [1:0] status);
      ptmt_pkg::req_type item;
      item.action       = action;
      item.seq_num      = seq;
      item.port         = port;
      item.time_sec     = sec;
      item.time_usec    = usec;
      item.entry_status = status;
      return item;
   endfunction

   // Offer one transaction after a random idle gap; hold it until taken.
   task automatic offer(input ptmt_pkg::req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= item;
      do begin
         @(posedge clock);
      end while (!(req_valid === 1'b1 && req_stall === 1'b0));
      if (item.action == ptmt_pkg::ACTION_INSERT) begin
         recent_probes.push_back(item);
         if (recent_probes.size() > 48) begin
            void'(recent_probes.pop_front());
         end
      end
   endtask

   // Drop valid and wait until every reply owed has been collected.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (outstanding == 0);
   endtask

   // Mostly well-formed traffic: inserts, then replies aimed at recent probes
   // with plausible receive times; the rest is noise lookups.
   function automatic ptmt_pkg::req_type random_probe();
      ptmt_pkg::req_type item;
      ptmt_pkg::req_type past;
      int unsigned       roll;
      roll              = $urandom_range(99);
      item.entry_status = 2'($urandom_range(3));
      item.time_usec    = ($urandom_range(19) == 0) ? 20'($urandom_range(20'hFFFFF, 1000000))
                                                    : 20'($urandom_range(999999));
      if (roll < 62) begin
         item.action = ptmt_pkg::ACTION_INSERT;
         case ($urandom_range(9))
            0:       item.seq_num = '0;
            1, 2, 3: item.seq_num = 16'($urandom_range(31, 1));
            default: item.seq_num = 16'($urandom);
         endcase
         item.port     = $urandom_range(1) ? 16'($urandom_range(1015, 1000)) : 16'($urandom);
         item.time_sec = ($urandom_range(3) == 0) ? $urandom : 32'(1000 + $urandom_range(50));
      end else if (roll < 92 && recent_probes.size() > 0) begin
         past        = recent_probes[$urandom_range(recent_probes.size() - 1)];
         item.action = ptmt_pkg::ACTION_MATCH;
         item.port   = past.port;
         // a zero sequence turns the reply into a lookup by port
         item.seq_num = ($urandom_range(3) == 0) ? 16'd0 : past.seq_num;
         case ($urandom_range(9))
            7: item.time_sec = past.time_sec - 1;
            8: item.time_sec = $urandom;
            9: begin
               item.time_sec  = past.time_sec;
               item.time_usec = past.time_usec;
            end
            default: item.time_sec = past.time_sec + $urandom_range(2);
         endcase
      end else begin
         item.action   = ptmt_pkg::ACTION_MATCH;
         item.seq_num  = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom);
         item.port     = $urandom_range(1) ? 16'd0 : 16'($urandom);
         item.time_sec = $urandom;
      end
      return item;
   endfunction

   // Directed opening: cleared entries, field extremes, saturation both ways,
   // the same-second borrow, duplicate sequences and port lookups.
   task automatic run_directed();
      // port lookup on an empty table hits the cleared entry at index 0
      offer(probe(ptmt_pkg::ACTION_MATCH, 16'd0, 16'd0, 32'd0, 20'd5, 2'd0));
      offer(probe(ptmt_pkg::ACTION_MATCH, 16'd0, 16'd0, 32'hFFFF_FFFF, 20'd999999, 2'd3));
      offer(probe(ptmt_pkg::ACTION_MATCH, 16'hFFFF, 16'hFFFF, 32'd10, 20'd0, 2'd0));
      // all-ones entry, microseconds above one second
      offer(probe(ptmt_pkg::ACTION_INSERT, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 20'hFFFFF, 2'd3));
      offer(probe(ptmt_pkg::ACTION_MATCH, 16'hFFFF, 16'd0, 32'd0, 20'd0, 2'd0));
      offer(probe(ptmt_pkg::ACTION_INSERT, 16'd1, 16'd1234, 32'd100, 20'd500000, 2'd0));
      // same second, earlier microseconds: borrow a second's worth
      offer(probe(ptmt_pkg::ACTION_MATCH, 16'd1, 16'd0, 32'd100, 20'd400000, 2'd0));
      offer(probe(ptmt_pkg::ACTION_MATCH, 16'd1, 16'd0, 32'd101, 20'd0, 2'd0));
      // a second entry with the same sequence; the lower index must still win
      offer(probe(ptmt_pkg::ACTION_INSERT, 16'd1, 16'd4321, 32'd200, 20'd0, 2'd2));
      offer(probe(ptmt_pkg::ACTION_MATCH, 16'd1, 16'd0, 32'd200, 20'd1, 2'd0));
      offer(probe(ptmt_pkg::ACTION_MATCH, 16'd0, 16'd4321, 32'd199, 20'd999999, 2'd0));
      offer(probe(ptmt_pkg::ACTION_MATCH, 16'd0, 16'hFFFF, 32'h8000_0000, 20'd0, 2'd0));
      offer(probe(ptmt_pkg::ACTION_MATCH, 16'd0, 16'd777, 32'd5, 20'd5, 2'd0));
      offer(probe(ptmt_pkg::ACTION_INSERT, 16'd0, 16'd0, 32'd5, 20'd0, 2'd0));
      offer(probe(ptmt_pkg::ACTION_MATCH, 16'd0, 16'd0, 32'd4, 20'd0, 2'd0));
      offer(probe(ptmt_pkg::ACTION_INSERT, 16'h8000, 16'h8000, 32'h8000_0000, 20'h80000, 2'd1));
      offer(probe(ptmt_pkg::ACTION_MATCH, 16'h8000, 16'h7FFF, 32'h8000_0864, 20'h7FFFF, 2'd1));
      settle();
   endtask

   initial begin
      req_valid   = 1'b0;
      req_payload = '0;
      reset       = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();

      // Phase 0: sender idles lightly, receiver stalls heavily.
      // Phase 1: the other way round. Phase 2: no idling on either side.
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 83 : 0;
         rsp_stall_pct = (phase == 0) ? 83 : (phase == 1) ? 33 : 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // hold the receiver off while the sender keeps going flat out
            if (phase == 2 && n == 10) begin
               rsp_hold_cycles = HOLD_CYCLES;
            end
            offer(random_probe());
         end
         settle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
